// ----- rtl/pr_pkg.sv -----
// ----------------------------------------------------------------------------
// pr_pkg
// Shared types, constants and the arctangent table of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pr_pkg;

    localparam logic [1:0] MODE_RECT  = 2'd0;
    localparam logic [1:0] MODE_POLAR = 2'd1;

    localparam int TABLE_LEN = 32;

    localparam logic signed [25:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
    localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
    localparam logic        [31:0] DEG_FULL_U  = 32'd23592960;

    localparam logic signed [33:0] UNIT_Q30     = 34'sd1073741824;
    localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

    typedef enum logic [1:0] {QD_0, QD_90, QD_180, QD_M90} quad_t;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [25:0] z;
        logic               flip;
        logic               spec;
        quad_t              quad;
    } red_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               err;
    } xy_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_val(input int idx);
        logic [21:0] v;
        case (idx)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pr_reduce.sv -----
// ----------------------------------------------------------------------------
// pr_reduce
// Angle reduction: remainder by 360 degrees over seven subtract stages,
// wrap into (-180, 180], axis detection and fold into [-90, 90].
// ----------------------------------------------------------------------------
`default_nettype none

module pr_reduce
    import pr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    out_valid,
    output red_t                    out_data
);

    localparam int DIV_STEPS = 7;

    logic                v_reg    [0:DIV_STEPS];
    logic        [1:0]   mode_reg [0:DIV_STEPS];
    logic signed [31:0]  a_reg    [0:DIV_STEPS];
    logic signed [31:0]  b_reg    [0:DIV_STEPS];
    logic                neg_reg  [0:DIV_STEPS];
    logic        [31:0]  rem_reg  [0:DIV_STEPS];

    logic                out_valid_reg;
    red_t                out_reg;
    red_t                out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg[0] <= mode;
        a_reg[0]    <= a;
        b_reg[0]    <= b;
        neg_reg[0]  <= b[31];
        rem_reg[0]  <= b[31] ? 32'(-b) : 32'(b);
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        localparam logic [31:0] SUB = DEG_FULL_U << (DIV_STEPS - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            mode_reg[j] <= mode_reg[j-1];
            a_reg[j]    <= a_reg[j-1];
            b_reg[j]    <= b_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            rem_reg[j]  <= (rem_reg[j-1] >= SUB) ? (rem_reg[j-1] - SUB) : rem_reg[j-1];
        end
    end

    always_comb
    begin
        logic signed [25:0] rm;
        logic signed [25:0] r;
        rm = $signed({1'b0, rem_reg[DIV_STEPS][24:0]});
        r  = neg_reg[DIV_STEPS] ? -rm : rm;
        if (r > DEG_HALF)
        begin
            r = r - DEG_FULL;
        end
        if (r <= -DEG_HALF)
        begin
            r = r + DEG_FULL;
        end
        out_next.mode = mode_reg[DIV_STEPS];
        out_next.a    = a_reg[DIV_STEPS];
        out_next.b    = b_reg[DIV_STEPS];
        out_next.spec = 1'b1;
        out_next.flip = 1'b0;
        out_next.z    = r;
        out_next.quad = QD_0;
        if (r == 26'sd0)
        begin
            out_next.quad = QD_0;
        end
        else if (r == DEG_QUARTER)
        begin
            out_next.quad = QD_90;
        end
        else if (r == DEG_HALF)
        begin
            out_next.quad = QD_180;
        end
        else if (r == -DEG_QUARTER)
        begin
            out_next.quad = QD_M90;
        end
        else
        begin
            out_next.spec = 1'b0;
            if (r > DEG_QUARTER)
            begin
                out_next.z    = r - DEG_HALF;
                out_next.flip = 1'b1;
            end
            else if (r < -DEG_QUARTER)
            begin
                out_next.z    = r + DEG_HALF;
                out_next.flip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/pr_rotate.sv -----
// ----------------------------------------------------------------------------
// pr_rotate
// Rotation CORDIC forming cos/sin in Q4.30, one iteration per stage, then
// magnitude scaling, rounding, saturation and form selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_rotate
    import pr_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire red_t in_data,
    output logic      out_valid,
    output xy_t       out_data
);

    localparam int N = ROTATION_STEPS;

    logic                v_reg [0:N-1];
    logic signed [33:0]  x_reg [0:N-1];
    logic signed [33:0]  y_reg [0:N-1];
    logic signed [25:0]  z_reg [0:N-1];
    red_t                d_reg [0:N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [25:0] AT = $signed({4'd0, atan_val(i)});

        logic               vs;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [25:0] zs;
        red_t               ds;

        if (i == 0)
        begin : g_src0
            assign vs = in_valid;
            assign xs = GAIN_INV_Q30;
            assign ys = 34'sd0;
            assign zs = in_data.z;
            assign ds = in_data;
        end
        else
        begin : g_srcn
            assign vs = v_reg[i-1];
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
            assign ds = d_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= vs;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[i] <= ds;
            if (zs >= 26'sd0)
            begin
                x_reg[i] <= xs - (ys >>> i);
                y_reg[i] <= ys + (xs >>> i);
                z_reg[i] <= zs - AT;
            end
            else
            begin
                x_reg[i] <= xs + (ys >>> i);
                y_reg[i] <= ys - (xs >>> i);
                z_reg[i] <= zs + AT;
            end
        end
    end

    // cos/sin select
    logic                f1_v_reg;
    logic signed [33:0]  c_reg;
    logic signed [33:0]  s_reg;
    red_t                f1_d_reg;
    logic signed [33:0]  c_next;
    logic signed [33:0]  s_next;

    always_comb
    begin
        red_t d;
        d = d_reg[N-1];
        c_next = d.flip ? -x_reg[N-1] : x_reg[N-1];
        s_next = d.flip ? -y_reg[N-1] : y_reg[N-1];
        if (d.spec)
        begin
            case (d.quad)
                QD_0:
                begin
                    c_next = UNIT_Q30;
                    s_next = 34'sd0;
                end
                QD_90:
                begin
                    c_next = 34'sd0;
                    s_next = UNIT_Q30;
                end
                QD_180:
                begin
                    c_next = -UNIT_Q30;
                    s_next = 34'sd0;
                end
                QD_M90:
                begin
                    c_next = 34'sd0;
                    s_next = -UNIT_Q30;
                end
                default:
                begin
                    c_next = UNIT_Q30;
                    s_next = 34'sd0;
                end
            endcase
        end
    end

    // products
    logic                f2_v_reg;
    logic signed [65:0]  px_reg;
    logic signed [65:0]  py_reg;
    red_t                f2_d_reg;
    logic signed [65:0]  px_next;
    logic signed [65:0]  py_next;

    assign px_next = f1_d_reg.a * c_reg;
    assign py_next = f1_d_reg.a * s_reg;

    // round, saturate, select
    logic                f3_v_reg;
    xy_t                 f3_reg;
    xy_t                 f3_next;

    function automatic logic signed [31:0] round_sat(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + 66'sd536870912) >>> 30;
        if (t > 66'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (t < -66'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return t[31:0];
    endfunction

    always_comb
    begin
        f3_next.err = f2_d_reg.mode[1];
        case (f2_d_reg.mode)
            MODE_RECT:
            begin
                f3_next.x = f2_d_reg.a;
                f3_next.y = f2_d_reg.b;
            end
            MODE_POLAR:
            begin
                f3_next.x = round_sat(px_reg);
                f3_next.y = round_sat(py_reg);
            end
            default:
            begin
                f3_next.x = 32'sd0;
                f3_next.y = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= v_reg[N-1];
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        s_reg    <= s_next;
        f1_d_reg <= d_reg[N-1];
        px_reg   <= px_next;
        py_reg   <= py_next;
        f2_d_reg <= f1_d_reg;
        f3_reg   <= f3_next;
    end

    assign out_valid = f3_v_reg;
    assign out_data  = f3_reg;

endmodule

`default_nettype wire

// ----- rtl/pr_isqrt.sv -----
// ----------------------------------------------------------------------------
// pr_isqrt
// Vector length: squares, sum, then a 32-stage digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_isqrt
    import pr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire xy_t         in_data,
    output logic             out_valid,
    output logic      [31:0] mag
);

    localparam int ROOT_STEPS = 32;

    logic               sq_v_reg;
    logic        [63:0] xx_reg;
    logic        [63:0] yy_reg;
    logic signed [63:0] pxx;
    logic signed [63:0] pyy;
    logic               sum_v_reg;
    logic        [63:0] sum_reg;

    logic               v_reg   [0:ROOT_STEPS-1];
    logic        [63:0] n_reg   [0:ROOT_STEPS-1];
    logic        [63:0] res_reg [0:ROOT_STEPS-1];

    assign pxx = in_data.x * in_data.x;
    assign pyy = in_data.y * in_data.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end
        else
        begin
            sq_v_reg  <= in_valid;
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg  <= $unsigned(pxx);
        yy_reg  <= $unsigned(pyy);
        sum_reg <= xx_reg + yy_reg;
    end

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

        logic        vs;
        logic [63:0] ns;
        logic [63:0] rs;
        logic [63:0] trial;

        if (k == 0)
        begin : g_src0
            assign vs = sum_v_reg;
            assign ns = sum_reg;
            assign rs = 64'd0;
        end
        else
        begin : g_srcn
            assign vs = v_reg[k-1];
            assign ns = n_reg[k-1];
            assign rs = res_reg[k-1];
        end

        assign trial = rs + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= vs;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ns >= trial)
            begin
                n_reg[k]   <= ns - trial;
                res_reg[k] <= (rs >> 1) + BIT;
            end
            else
            begin
                n_reg[k]   <= ns;
                res_reg[k] <= rs >> 1;
            end
        end
    end

    assign out_valid = v_reg[ROOT_STEPS-1];
    assign mag       = res_reg[ROOT_STEPS-1][31:0];

endmodule

`default_nettype wire

// ----- rtl/pr_vector.sv -----
// ----------------------------------------------------------------------------
// pr_vector
// Direction: axis cases, half-plane fold, vectoring CORDIC over 32 stages
// (stages past ROTATION_STEPS only hold), then clamp to +-180 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_vector
    import pr_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire xy_t         in_data,
    output logic             out_valid,
    output xy_t              out_data,
    output logic signed [24:0] angle
);

    localparam int N = ROTATION_STEPS;

    logic                p_v_reg;
    logic signed [59:0]  p_x_reg;
    logic signed [59:0]  p_y_reg;
    logic signed [26:0]  p_z_reg;
    logic                p_spec_reg;
    logic signed [24:0]  p_sz_reg;
    xy_t                 p_d_reg;

    logic signed [59:0]  p_x_next;
    logic signed [59:0]  p_y_next;
    logic signed [26:0]  p_z_next;
    logic                p_spec_next;
    logic signed [24:0]  p_sz_next;

    always_comb
    begin
        logic signed [32:0] xe;
        logic signed [32:0] ye;
        xe = {in_data.x[31], in_data.x};
        ye = {in_data.y[31], in_data.y};
        p_spec_next = 1'b1;
        p_sz_next   = 25'sd0;
        p_z_next    = 27'sd0;
        if (in_data.x == 32'sd0 && in_data.y == 32'sd0)
        begin
            p_sz_next = 25'sd0;
        end
        else if (in_data.y == 32'sd0)
        begin
            p_sz_next = (in_data.x > 32'sd0) ? 25'sd0 : 25'(DEG_HALF);
        end
        else if (in_data.x == 32'sd0)
        begin
            p_sz_next = (in_data.y > 32'sd0) ? 25'(DEG_QUARTER) : 25'(-DEG_QUARTER);
        end
        else
        begin
            p_spec_next = 1'b0;
        end
        if (in_data.x < 32'sd0)
        begin
            p_z_next = (in_data.y > 32'sd0) ? 27'(DEG_HALF) : 27'(-DEG_HALF);
            xe = -xe;
            ye = -ye;
        end
        p_x_next = {{3{xe[32]}}, xe, 24'd0};
        p_y_next = {{3{ye[32]}}, ye, 24'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_x_reg    <= p_x_next;
        p_y_reg    <= p_y_next;
        p_z_reg    <= p_z_next;
        p_spec_reg <= p_spec_next;
        p_sz_reg   <= p_sz_next;
        p_d_reg    <= in_data;
    end

    logic                v_reg    [0:TABLE_LEN-1];
    logic signed [59:0]  x_reg    [0:TABLE_LEN-1];
    logic signed [59:0]  y_reg    [0:TABLE_LEN-1];
    logic signed [26:0]  z_reg    [0:TABLE_LEN-1];
    logic                spec_reg [0:TABLE_LEN-1];
    logic signed [24:0]  sz_reg   [0:TABLE_LEN-1];
    xy_t                 d_reg    [0:TABLE_LEN-1];

    for (genvar i = 0; i < TABLE_LEN; i++)
    begin : g_iter
        localparam logic signed [26:0] AT = $signed({5'd0, atan_val(i)});

        logic               vs;
        logic signed [59:0] xs;
        logic signed [59:0] ys;
        logic signed [26:0] zs;
        logic               ss;
        logic signed [24:0] szs;
        xy_t                ds;

        if (i == 0)
        begin : g_src0
            assign vs  = p_v_reg;
            assign xs  = p_x_reg;
            assign ys  = p_y_reg;
            assign zs  = p_z_reg;
            assign ss  = p_spec_reg;
            assign szs = p_sz_reg;
            assign ds  = p_d_reg;
        end
        else
        begin : g_srcn
            assign vs  = v_reg[i-1];
            assign xs  = x_reg[i-1];
            assign ys  = y_reg[i-1];
            assign zs  = z_reg[i-1];
            assign ss  = spec_reg[i-1];
            assign szs = sz_reg[i-1];
            assign ds  = d_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= vs;
            end
        end

        if (i < N)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (ys >= 60'sd0)
                begin
                    x_reg[i] <= xs + (ys >>> i);
                    y_reg[i] <= ys - (xs >>> i);
                    z_reg[i] <= zs + AT;
                end
                else
                begin
                    x_reg[i] <= xs - (ys >>> i);
                    y_reg[i] <= ys + (xs >>> i);
                    z_reg[i] <= zs - AT;
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                x_reg[i] <= xs;
                y_reg[i] <= ys;
                z_reg[i] <= zs;
            end
        end

        always_ff @(posedge clk)
        begin
            spec_reg[i] <= ss;
            sz_reg[i]   <= szs;
            d_reg[i]    <= ds;
        end
    end

    logic                out_v_reg;
    logic signed [24:0]  angle_reg;
    logic signed [24:0]  angle_next;
    xy_t                 out_reg;

    always_comb
    begin
        logic signed [26:0] z;
        z = z_reg[TABLE_LEN-1];
        if (z > 27'(DEG_HALF))
        begin
            z = 27'(DEG_HALF);
        end
        if (z < 27'(-DEG_HALF))
        begin
            z = 27'(-DEG_HALF);
        end
        angle_next = spec_reg[TABLE_LEN-1] ? sz_reg[TABLE_LEN-1] : z[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[TABLE_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        out_reg   <= d_reg[TABLE_LEN-1];
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign angle     = angle_reg;

endmodule

`default_nettype wire

// ----- rtl/polar_rectangular_converter_top.sv -----
// ----------------------------------------------------------------------------
// polar_rectangular_converter_top
// Converts a vector given in rectangular or polar form into both forms.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer is taken on each rising edge with start high and busy low.
//   busy is always low: the pipeline takes one item every cycle.
//   mode selects the form: rectangular x,y or polar magnitude,angle.
//   Each item gives one result, marked by done for one cycle, with x_out,
//   y_out, magnitude, angle_deg, mode_error. The result path runs through
//   9 angle-reduction stages, the rotation CORDIC (ROTATION_STEPS stages
//   plus select, multiply and round stages) and the 34-stage length path
//   (squares, sum, square root), which runs alongside the vectoring CORDIC.
//   Throughput: one item per cycle, results in input order.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; results are shown once.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_rectangular_converter_top
    import pr_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] first_value,
    input  wire logic signed [31:0] second_value,
    output logic                    done,
    output logic signed [31:0]      x_out,
    output logic signed [31:0]      y_out,
    output logic        [31:0]      magnitude,
    output logic signed [24:0]      angle_deg,
    output logic                    mode_error
);

    logic  red_valid;
    red_t  red_data;
    logic  rot_valid;
    xy_t   rot_data;
    logic  sq_valid;
    logic  vec_valid;
    xy_t   vec_data;

    assign busy = 1'b0;

    pr_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .mode      (mode),
        .a         (first_value),
        .b         (second_value),
        .out_valid (red_valid),
        .out_data  (red_data)
    );

    pr_rotate #(.ROTATION_STEPS(ROTATION_STEPS)) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_data   (red_data),
        .out_valid (rot_valid),
        .out_data  (rot_data)
    );

    pr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_data   (rot_data),
        .out_valid (sq_valid),
        .mag       (magnitude)
    );

    pr_vector #(.ROTATION_STEPS(ROTATION_STEPS)) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_data   (rot_data),
        .out_valid (vec_valid),
        .out_data  (vec_data),
        .angle     (angle_deg)
    );

    assign done       = vec_valid & sq_valid;
    assign x_out      = vec_data.x;
    assign y_out      = vec_data.y;
    assign mode_error = vec_data.err;

endmodule

`default_nettype wire

// ----- rtl/pr_checker.sv -----
// ----------------------------------------------------------------------------
// pr_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pr_checker
    import pr_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic        [1:0]  mode,
    input wire logic               done,
    input wire logic signed [31:0] x_out,
    input wire logic signed [31:0] y_out,
    input wire logic        [31:0] magnitude,
    input wire logic signed [24:0] angle_deg,
    input wire logic               mode_error
);

    localparam int LAT = ROTATION_STEPS + 46;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT (done && (mode_error == $past(mode[1], LAT))))
        else $error("result missing or wrong error flag");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_error) |-> (x_out == 32'sd0 && y_out == 32'sd0 &&
                                  magnitude == 32'd0 && angle_deg == 25'sd0))
        else $error("error result not zero");

    a_axis_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && y_out == 32'sd0) |->
        (magnitude == (x_out[31] ? 32'(-x_out) : 32'(x_out))))
        else $error("axis magnitude mismatch");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_deg <= 25'(DEG_HALF) && angle_deg >= 25'(-DEG_HALF)))
        else $error("angle out of range");

endmodule

bind polar_rectangular_converter_top pr_checker #(.ROTATION_STEPS(ROTATION_STEPS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .done         (done),
    .x_out        (x_out),
    .y_out        (y_out),
    .magnitude    (magnitude),
    .angle_deg    (angle_deg),
    .mode_error   (mode_error)
);

`default_nettype wire

// ----- verif/polar_rectangular_converter_checker.sv -----
// ----------------------------------------------------------------------------
// polar_rectangular_converter_checker
// Watches both transfer channels of the converter, predicts x, y, length and
// direction for every accepted vector, and compares each result with the
// oldest open prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_rectangular_converter_checker
    import pr_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] first_value,
    input  wire logic signed [31:0] second_value,
    input  wire logic               done,
    input  wire logic signed [31:0] x_out,
    input  wire logic signed [31:0] y_out,
    input  wire logic        [31:0] magnitude,
    input  wire logic signed [24:0] angle_deg,
    input  wire logic               mode_error,
    output int                      errors,
    output int                      pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HALF_TURN    = 64'sd11796480;
    localparam longint QUARTER_TURN = 64'sd5898240;
    localparam longint FULL_TURN    = 64'sd23592960;
    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint GAIN_Q30     = 64'sd652032874;
    localparam longint PRESCALE     = 64'sd16777216;
    localparam int     NUM_STEPS    = (ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS;

    localparam longint ARCTAN [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] len;
        logic signed [24:0] dir;
        logic               err;
    } vector_t;

    vector_t expected_vectors[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint heading(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (y == 0)
            return (x > 0) ? 0 : HALF_TURN;
        if (x == 0)
            return (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
        if (x < 0)
        begin
            z = (y > 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        x = x * PRESCALE;
        y = y * PRESCALE;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + ARCTAN[i];
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - ARCTAN[i];
            end
        end
        if (z > HALF_TURN)
            z = HALF_TURN;
        if (z < -HALF_TURN)
            z = -HALF_TURN;
        return z;
    endfunction

    task automatic unit_vector(input longint ang, output longint c, output longint s);
        longint r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        r = ang % FULL_TURN;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (r > HALF_TURN)
            r = r - FULL_TURN;
        if (r <= -HALF_TURN)
            r = r + FULL_TURN;
        if (r == 0)
        begin
            c = ONE_Q30;
            s = 0;
        end
        else if (r == QUARTER_TURN)
        begin
            c = 0;
            s = ONE_Q30;
        end
        else if (r == HALF_TURN)
        begin
            c = -ONE_Q30;
            s = 0;
        end
        else if (r == -QUARTER_TURN)
        begin
            c = 0;
            s = -ONE_Q30;
        end
        else
        begin
            if (r > QUARTER_TURN)
            begin
                r = r - HALF_TURN;
                flip = 1;
            end
            else if (r < -QUARTER_TURN)
            begin
                r = r + HALF_TURN;
                flip = 1;
            end
            for (int i = 0; i < NUM_STEPS; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (r >= 0)
                begin
                    x = x - dy;
                    y = y + dx;
                    r = r - ARCTAN[i];
                end
                else
                begin
                    x = x + dy;
                    y = y - dx;
                    r = r + ARCTAN[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = x;
            s = y;
        end
    endtask

    task automatic convert(input logic [1:0] m, input longint a, input longint b,
                           output vector_t v);
        longint          x;
        longint          y;
        longint          c;
        longint          s;
        longint unsigned len;
        x = 0;
        y = 0;
        if (m == MODE_RECT)
        begin
            x = a;
            y = b;
        end
        else if (m == MODE_POLAR)
        begin
            unit_vector(b, c, s);
            x = clamp32((a * c + (64'sd1 <<< 29)) >>> 30);
            y = clamp32((a * s + (64'sd1 <<< 29)) >>> 30);
        end
        len = int_sqrt(longint'(x * x) + longint'(y * y));
        if (len > 64'hFFFF_FFFF)
            len = 64'hFFFF_FFFF;
        v.x   = x[31:0];
        v.y   = y[31:0];
        v.len = len[31:0];
        v.dir = 25'(heading(x, y));
        v.err = (m != MODE_RECT && m != MODE_POLAR);
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        vector_t v;
        vector_t e;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                convert(mode, longint'(first_value), longint'(second_value), v);
                expected_vectors.push_back(v);
            end
            if (done)
            begin
                if (expected_vectors.size() == 0)
                begin
                    $display("%0t: unexpected result transfer x=%0d y=%0d", $time,
                             x_out, y_out);
                    errors++;
                end
                else
                begin
                    e = expected_vectors.pop_front();
                    if (x_out !== e.x)
                    begin
                        $display("%0t: x_out exp %0d got %0d", $time, e.x, x_out);
                        errors++;
                    end
                    if (y_out !== e.y)
                    begin
                        $display("%0t: y_out exp %0d got %0d", $time, e.y, y_out);
                        errors++;
                    end
                    if (magnitude !== e.len)
                    begin
                        $display("%0t: magnitude exp %0d got %0d", $time, e.len,
                                 magnitude);
                        errors++;
                    end
                    if (angle_deg !== e.dir)
                    begin
                        $display("%0t: angle_deg exp %0d got %0d", $time, e.dir,
                                 angle_deg);
                        errors++;
                    end
                    if (mode_error !== e.err)
                    begin
                        $display("%0t: mode_error exp %0b got %0b", $time, e.err,
                                 mode_error);
                        errors++;
                    end
                end
            end
            pending <= expected_vectors.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_polar_rectangular_converter_top.sv -----
// ----------------------------------------------------------------------------
// tb_polar_rectangular_converter_top
// Drives directed and random rectangular, polar and invalid vectors into the
// converter with varying input gaps; the checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polar_rectangular_converter_top;

    import pr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RANDOM_ITEMS   = 250;
    localparam longint ONE            = 64'sd65536;
    localparam longint QTR            = 64'sd5898240;
    localparam logic [1:0] MODE_BAD2  = 2'd2;
    localparam logic [1:0] MODE_BAD3  = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic        [1:0]  mode;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               done;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic        [31:0] magnitude;
    logic signed [24:0] angle_deg;
    logic               mode_error;
    int                 errors;
    int                 pending;
    int                 idle_pct;
    int                 quiet_cycles;

    polar_rectangular_converter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .first_value  (first_value),
        .second_value (second_value),
        .done         (done),
        .x_out        (x_out),
        .y_out        (y_out),
        .magnitude    (magnitude),
        .angle_deg    (angle_deg),
        .mode_error   (mode_error)
    );

    polar_rectangular_converter_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .first_value  (first_value),
        .second_value (second_value),
        .done         (done),
        .x_out        (x_out),
        .y_out        (y_out),
        .magnitude    (magnitude),
        .angle_deg    (angle_deg),
        .mode_error   (mode_error),
        .errors       (errors),
        .pending      (pending)
    );

    initial
        clk = 0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** polar_rectangular_converter_top: FAILED **");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send(input logic [1:0] m, input longint a, input longint b);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 0;
            @(negedge clk);
        end
        start = 1;
        mode = m;
        first_value = a[31:0];
        second_value = b[31:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic longint any_value();
        case ($urandom_range(5))
            0:       return longint'($signed($urandom()));
            1:       return longint'($signed(32'($urandom_range(2 * 65536)))) - ONE;
            2:       return $urandom_range(1) ? 64'sd2147483647 - $urandom_range(3)
                                              : -64'sd2147483648 + $urandom_range(3);
            3:       return $urandom_range(1) ? 0 : -longint'($urandom_range(100));
            default: return longint'($signed(32'($urandom_range(200 * 65536)))) - 100 * ONE;
        endcase
    endfunction

    function automatic longint any_angle();
        longint k;
        k = longint'($urandom_range(8)) - 4;
        case ($urandom_range(3))
            0:       return k * QTR + longint'($urandom_range(4)) - 2;
            1:       return k * QTR;
            2:       return longint'($signed($urandom()));
            default: return longint'($urandom_range(2 * 11796480)) - 11796480;
        endcase
    endfunction

    task automatic random_phase(input int pct);
        int r;
        idle_pct = pct;
        repeat (RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 40)
                send(MODE_RECT, any_value(), any_value());
            else if (r < 88)
                send(MODE_POLAR, any_value(), any_angle());
            else
                send($urandom_range(1) ? MODE_BAD2 : MODE_BAD3,
                     longint'($signed($urandom())), longint'($signed($urandom())));
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        mode = MODE_RECT;
        first_value = 0;
        second_value = 0;
        idle_pct = 0;
        quiet_cycles = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(MODE_RECT, 0, 0);
        send(MODE_RECT, 64'sd2147483647, 64'sd2147483647);
        send(MODE_RECT, -64'sd2147483648, -64'sd2147483648);
        send(MODE_RECT, -64'sd2147483648, 0);
        send(MODE_RECT, 0, -64'sd2147483648);
        send(MODE_RECT, -5 * ONE, 0);
        send(MODE_RECT, 0, 5 * ONE);
        send(MODE_RECT, 3 * ONE, -4 * ONE);
        send(MODE_POLAR, ONE, 0);
        send(MODE_POLAR, ONE, QTR);
        send(MODE_POLAR, ONE, -QTR);
        send(MODE_POLAR, ONE, 2 * QTR);
        send(MODE_POLAR, ONE, -2 * QTR);
        send(MODE_POLAR, ONE, 3 * QTR);
        send(MODE_POLAR, ONE, 8 * QTR);
        send(MODE_POLAR, ONE, QTR / 2);
        send(MODE_POLAR, -2 * ONE, -3 * QTR / 2);
        send(MODE_POLAR, 64'sd2147483647, QTR / 2);
        send(MODE_POLAR, -64'sd2147483648, 2 * QTR);
        send(MODE_POLAR, 10 * ONE, 64'sd2147483647);
        send(MODE_POLAR, 10 * ONE, -64'sd2147483648);
        send(MODE_BAD2, 7 * ONE, 9 * ONE);
        send(MODE_BAD3, -1, -1);

        start = 0;
        while (pending != 0)
            @(negedge clk);

        random_phase(26);
        random_phase(61);
        random_phase(0);
        start = 0;

        while (pending != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("** polar_rectangular_converter_top: PASSED **");
        else
            $display("** polar_rectangular_converter_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- polar_rectangular_converter_top.f -----
rtl/pr_pkg.sv
rtl/pr_reduce.sv
rtl/pr_rotate.sv
rtl/pr_isqrt.sv
rtl/pr_vector.sv
rtl/polar_rectangular_converter_top.sv
rtl/pr_checker.sv
verif/polar_rectangular_converter_checker.sv
verif/tb_polar_rectangular_converter_top.sv
